[sv/scm_pkg.sv]
// shared types, constants and helpers for the sparse complex matrix multiply
`timescale 1ns / 1ps
package scm_pkg;

  localparam int MAX_ROWS  = 64;
  localparam int MAX_INNER = 64;
  localparam int MAX_COLS  = 64;
  localparam int NNZ_A     = 1024;
  localparam int NNZ_B     = 1024;

  localparam int IDX_W  = 6;
  localparam int SIZE_W = 7;
  localparam int THR_W  = 39;
  localparam int VAL_W  = 16;
  localparam int PVAL_W = 2 * VAL_W;
  localparam int SUM_W  = 40;

  localparam int A_AW   = $clog2(NNZ_A);
  localparam int A_CW   = $clog2(NNZ_A + 1);
  localparam int B_AW   = $clog2(NNZ_B);
  localparam int B_CW   = $clog2(NNZ_B + 1);
  localparam int CNT_W  = (A_CW > B_CW) ? A_CW : B_CW;
  localparam int ROW_AW = $clog2(MAX_ROWS);
  localparam int COL_AW = $clog2(MAX_COLS);

  localparam int CQ_DEPTH = 4;
  localparam int CQ_AW    = $clog2(CQ_DEPTH);

  localparam logic [SIZE_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [1:0] {
    OP_CLEAR   = 2'd0,
    OP_LOAD_A  = 2'd1,
    OP_LOAD_B  = 2'd2,
    OP_COMPUTE = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ERROR = 2'd2,
    ST_FULL  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CFG_ROWS  = 2'd0,
    CFG_INNER = 2'd1,
    CFG_COLS  = 2'd2,
    CFG_THR   = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    CMD_CLEAR,
    CMD_STORE_A,
    CMD_STORE_B,
    CMD_REPLY,
    CMD_COMPUTE
  } cmd_kind_t;

  typedef struct packed {
    op_t                     operation;
    logic [IDX_W-1:0]        row_idx;
    logic [IDX_W-1:0]        col_idx;
    logic signed [VAL_W-1:0] val_re;
    logic signed [VAL_W-1:0] val_im;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]        out_row;
    logic [IDX_W-1:0]        out_col;
    logic signed [SUM_W-1:0] out_re;
    logic signed [SUM_W-1:0] out_im;
    status_t                 status;
    logic                    last;
  } out_item_t;

  typedef struct packed {
    logic [SIZE_W-1:0] rows_used;
    logic [SIZE_W-1:0] inner_used;
    logic [SIZE_W-1:0] cols_used;
    logic [THR_W-1:0]  zero_threshold;
  } cfg_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [IDX_W-1:0]   row;
    logic [IDX_W-1:0]   col;
    logic [PVAL_W-1:0]  val;
    status_t            status;
    logic [CNT_W-1:0]   addr;
    logic [CNT_W-1:0]   first;
    logic [CNT_W-1:0]   col_end;
    logic               rebuild;
  } cmd_t;

  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input int max_v);
    logic [SIZE_W-1:0] r;
    r = v;
    if (v == '0) r = SIZE_W'(1);
    else if (int'(v) > max_v) r = SIZE_W'(max_v);
    return r;
  endfunction

endpackage

[sv/scm_front.sv]
// front end: checks each beat and turns it into a command for the back end
`timescale 1ns / 1ps
module scm_front (
  input  logic            clk,
  input  logic            rst_n,
  input  scm_pkg::cfg_t   cfg,
  input  logic            in_push,
  input  scm_pkg::in_item_t in_data,
  output logic            in_full,
  output logic            cq_push,
  output scm_pkg::cmd_t   cq_data,
  input  logic            cq_full
);
  import scm_pkg::*;

  logic [A_CW-1:0]  a_cnt_r, a_cnt_nxt;
  logic [IDX_W-1:0] a_lr_r, a_lr_nxt, a_lc_r, a_lc_nxt;
  logic [B_CW-1:0]  b_cnt_r, b_cnt_nxt, b_first_r, b_first_nxt;
  logic [IDX_W-1:0] b_lr_r, b_lr_nxt, b_lc_r, b_lc_nxt;
  logic             at_ok_r, at_ok_nxt;
  logic [SIZE_W-1:0] nrows, ninner, ncols;
  logic [SIZE_W-1:0] row_x, col_x;
  logic [B_CW-1:0]   b_first;
  cmd_t cmd;

  assign nrows   = clamp_size(cfg.rows_used, MAX_ROWS);
  assign ninner  = clamp_size(cfg.inner_used, MAX_INNER);
  assign ncols   = clamp_size(cfg.cols_used, MAX_COLS);
  assign row_x   = {1'b0, in_data.row_idx};
  assign col_x   = {1'b0, in_data.col_idx};
  assign b_first = (b_cnt_r == '0 || in_data.col_idx != b_lc_r) ? b_cnt_r : b_first_r;

  assign in_full = cq_full;
  assign cq_push = in_push && !cq_full;
  assign cq_data = cmd;

  always_comb begin
    cmd         = '0;
    cmd.kind    = CMD_REPLY;
    cmd.row     = in_data.row_idx;
    cmd.col     = in_data.col_idx;
    cmd.val     = {in_data.val_im, in_data.val_re};
    cmd.status  = ST_ERROR;
    a_cnt_nxt   = a_cnt_r;
    a_lr_nxt    = a_lr_r;
    a_lc_nxt    = a_lc_r;
    b_cnt_nxt   = b_cnt_r;
    b_lr_nxt    = b_lr_r;
    b_lc_nxt    = b_lc_r;
    b_first_nxt = b_first_r;
    at_ok_nxt   = at_ok_r;
    unique case (in_data.operation)
      OP_CLEAR: begin
        cmd.kind  = CMD_CLEAR;
        a_cnt_nxt = '0;
        b_cnt_nxt = '0;
        at_ok_nxt = 1'b0;
      end
      OP_LOAD_A: begin
        if (row_x >= nrows || col_x >= ninner) begin
          cmd.status = ST_ERROR;
        end else if (a_cnt_r != '0 && (in_data.col_idx < a_lc_r ||
                     (in_data.col_idx == a_lc_r && in_data.row_idx <= a_lr_r))) begin
          cmd.status = ST_ERROR;
        end else if (a_cnt_r >= A_CW'(NNZ_A)) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.kind  = CMD_STORE_A;
          cmd.addr  = CNT_W'(a_cnt_r);
          a_cnt_nxt = a_cnt_r + 1'b1;
          a_lr_nxt  = in_data.row_idx;
          a_lc_nxt  = in_data.col_idx;
          at_ok_nxt = 1'b0;
        end
      end
      OP_LOAD_B: begin
        if (row_x >= ninner || col_x >= ncols) begin
          cmd.status = ST_ERROR;
        end else if (b_cnt_r != '0 && (in_data.col_idx < b_lc_r ||
                     (in_data.col_idx == b_lc_r && in_data.row_idx <= b_lr_r))) begin
          cmd.status = ST_ERROR;
        end else if (b_cnt_r >= B_CW'(NNZ_B)) begin
          cmd.status = ST_FULL;
        end else begin
          cmd.kind    = CMD_STORE_B;
          cmd.addr    = CNT_W'(b_cnt_r);
          cmd.first   = CNT_W'(b_first);
          cmd.col_end = CNT_W'(b_cnt_r + 1'b1);
          b_cnt_nxt   = b_cnt_r + 1'b1;
          b_lr_nxt    = in_data.row_idx;
          b_lc_nxt    = in_data.col_idx;
          b_first_nxt = b_first;
        end
      end
      OP_COMPUTE: begin
        cmd.row = '0;
        if (col_x >= ncols) begin
          cmd.status = ST_ERROR;
        end else begin
          cmd.kind    = CMD_COMPUTE;
          cmd.addr    = CNT_W'(a_cnt_r);
          cmd.rebuild = !at_ok_r;
          at_ok_nxt   = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_cnt_r <= '0;
      b_cnt_r <= '0;
      at_ok_r <= 1'b0;
    end else if (cq_push) begin
      a_cnt_r   <= a_cnt_nxt;
      a_lr_r    <= a_lr_nxt;
      a_lc_r    <= a_lc_nxt;
      b_cnt_r   <= b_cnt_nxt;
      b_lr_r    <= b_lr_nxt;
      b_lc_r    <= b_lc_nxt;
      b_first_r <= b_first_nxt;
      at_ok_r   <= at_ok_nxt;
    end
  end

endmodule

[sv/scm_cmdq.sv]
// short command queue between the front end and the back end
`timescale 1ns / 1ps
module scm_cmdq (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  scm_pkg::cmd_t wdata,
  output logic          full,
  input  logic          pop,
  output scm_pkg::cmd_t rdata,
  output logic          empty
);
  import scm_pkg::*;

  cmd_t             q_r [CQ_DEPTH];
  logic [CQ_AW-1:0] wp_r, rp_r;
  logic [CQ_AW:0]   cnt_r;
  logic             do_push, do_pop;

  assign full    = (cnt_r == (CQ_AW + 1)'(CQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign rdata   = q_r[rp_r];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_ff @(posedge clk) begin
    if (do_push) q_r[wp_r] <= wdata;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= (wp_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : wp_r + 1'b1;
      if (do_pop)  rp_r <= (rp_r == CQ_AW'(CQ_DEPTH - 1)) ? '0 : rp_r + 1'b1;
      if (do_push && !do_pop) cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

[sv/scm_back.sv]
// back end: entry stores, row-major rebuild, row merge and result output
`timescale 1ns / 1ps
module scm_back (
  input  logic               clk,
  input  logic               rst_n,
  input  scm_pkg::cfg_t      cfg,
  input  logic               cq_empty,
  input  scm_pkg::cmd_t      cq_data,
  output logic               cq_pop,
  output logic               out_empty,
  input  logic               out_pop,
  output scm_pkg::out_item_t out_data
);
  import scm_pkg::*;

  typedef struct packed {
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [PVAL_W-1:0] val;
  } a_ent_t;

  typedef struct packed {
    logic [IDX_W-1:0]  key;
    logic [PVAL_W-1:0] val;
  } k_ent_t;

  typedef struct packed {
    logic [B_CW-1:0] first;
    logic [B_CW-1:0] col_end;
  } bcol_t;

  typedef enum logic [4:0] {
    S_IDLE, S_PUSH, S_ZERO, S_CNT_A, S_CNT_B, S_CNT_C, S_PFX_A, S_PFX_B,
    S_PL_A, S_PL_B, S_PL_C, S_ROW_A, S_ROW_B, S_MRG_A, S_MRG_B, S_FIN,
    S_NEXT, S_END
  } state_t;

  a_ent_t amem [NNZ_A];
  k_ent_t atmem [NNZ_A];
  k_ent_t bmem [NNZ_B];
  bcol_t  bcol [MAX_COLS];
  logic [A_CW-1:0] rowmem [MAX_ROWS];

  a_ent_t amem_q, ent_r;
  k_ent_t at_q, b_q;
  bcol_t  bcol_q;
  logic [A_CW-1:0] row_q;

  state_t state_r, ret_r;
  logic [MAX_COLS-1:0] bvalid_r;
  logic [IDX_W-1:0]  col_r;
  logic [A_CW-1:0]   acnt_r, i_r, run_r, prev_end_r, ap_r, ae_r;
  logic [B_CW-1:0]   bp_r, be_r;
  logic [SIZE_W-1:0] r_r;
  logic signed [SUM_W-1:0]  sre_r, sim_r;
  logic signed [PVAL_W-1:0] p0_r, p1_r, p2_r, p3_r;
  logic      pv_r, pend_v_r, out_v_r;
  out_item_t pend_r, res_r, out_r, cur, pend_last;

  logic              store_a, store_b, row_we, pass, free;
  logic [ROW_AW-1:0] row_waddr, row_raddr;
  logic [A_CW-1:0]   row_wdata;
  logic [SIZE_W-1:0] nrows;
  logic [SUM_W-1:0]  mag_re, mag_im, thr;
  logic signed [VAL_W-1:0] ar, ai, br, bi;

  function automatic logic [SUM_W-1:0] mag(input logic signed [SUM_W-1:0] v);
    return v[SUM_W-1] ? SUM_W'(-v) : SUM_W'(v);
  endfunction

  assign cq_pop    = (state_r == S_IDLE) && !cq_empty;
  assign store_a   = cq_pop && cq_data.kind == CMD_STORE_A;
  assign store_b   = cq_pop && cq_data.kind == CMD_STORE_B;
  assign out_empty = !out_v_r;
  assign out_data  = out_r;
  assign free      = !out_v_r || out_pop;
  assign nrows     = clamp_size(cfg.rows_used, MAX_ROWS);

  assign ar = signed'(at_q.val[VAL_W-1:0]);
  assign ai = signed'(at_q.val[PVAL_W-1:VAL_W]);
  assign br = signed'(b_q.val[VAL_W-1:0]);
  assign bi = signed'(b_q.val[PVAL_W-1:VAL_W]);

  assign mag_re = mag(sre_r);
  assign mag_im = mag(sim_r);
  assign thr    = SUM_W'(cfg.zero_threshold);
  assign pass   = (mag_re > thr) || (mag_im > thr);

  always_comb begin
    cur         = '0;
    cur.out_row = r_r[IDX_W-1:0];
    cur.out_col = col_r;
    cur.out_re  = sre_r;
    cur.out_im  = sim_r;
    cur.status  = ST_OK;
  end

  always_comb begin
    pend_last      = pend_r;
    pend_last.last = 1'b1;
  end

  always_comb begin
    row_we    = 1'b0;
    row_waddr = r_r[ROW_AW-1:0];
    row_wdata = '0;
    row_raddr = r_r[ROW_AW-1:0];
    unique case (state_r)
      S_ZERO: row_we = 1'b1;
      S_CNT_B, S_PL_B: row_raddr = amem_q.row[ROW_AW-1:0];
      S_CNT_C: begin
        row_we    = 1'b1;
        row_waddr = ent_r.row[ROW_AW-1:0];
        row_wdata = row_q + 1'b1;
      end
      S_PFX_B: begin
        row_we    = 1'b1;
        row_wdata = run_r;
      end
      S_PL_C: begin
        row_we    = 1'b1;
        row_waddr = ent_r.row[ROW_AW-1:0];
        row_wdata = row_q + 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (store_a) amem[cq_data.addr[A_AW-1:0]] <= {cq_data.row, cq_data.col, cq_data.val};
    amem_q <= amem[i_r[A_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state_r == S_PL_C) atmem[row_q[A_AW-1:0]] <= {ent_r.col, ent_r.val};
    at_q <= atmem[ap_r[A_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (store_b) bmem[cq_data.addr[B_AW-1:0]] <= {cq_data.row, cq_data.val};
    b_q <= bmem[bp_r[B_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (store_b) begin
      bcol[cq_data.col[COL_AW-1:0]] <= {cq_data.first[B_CW-1:0], cq_data.col_end[B_CW-1:0]};
    end
    bcol_q <= bcol[col_r[COL_AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (row_we) rowmem[row_waddr] <= row_wdata;
    row_q <= rowmem[row_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      ret_r    <= S_IDLE;
      bvalid_r <= '0;
      pv_r     <= 1'b0;
      pend_v_r <= 1'b0;
      out_v_r  <= 1'b0;
    end else begin
      if (state_r == S_PUSH && free) out_v_r <= 1'b1;
      else if (out_pop) out_v_r <= 1'b0;
      pv_r <= (state_r == S_MRG_B) && (at_q.key == b_q.key);
      if (pv_r) begin
        sre_r <= sre_r + SUM_W'(p0_r) - SUM_W'(p1_r);
        sim_r <= sim_r + SUM_W'(p2_r) + SUM_W'(p3_r);
      end
      unique case (state_r)
        S_IDLE: begin
          if (!cq_empty) begin
            unique case (cq_data.kind)
              CMD_CLEAR: bvalid_r <= '0;
              CMD_STORE_A: ;
              CMD_STORE_B: bvalid_r[cq_data.col[COL_AW-1:0]] <= 1'b1;
              CMD_REPLY: begin
                res_r.out_row <= cq_data.row;
                res_r.out_col <= cq_data.col;
                res_r.out_re  <= '0;
                res_r.out_im  <= '0;
                res_r.status  <= cq_data.status;
                res_r.last    <= 1'b1;
                ret_r         <= S_IDLE;
                state_r       <= S_PUSH;
              end
              CMD_COMPUTE: begin
                col_r      <= cq_data.col;
                acnt_r     <= cq_data.addr[A_CW-1:0];
                pend_v_r   <= 1'b0;
                r_r        <= '0;
                i_r        <= '0;
                prev_end_r <= '0;
                state_r    <= cq_data.rebuild ? S_ZERO : S_ROW_A;
              end
              default: ;
            endcase
          end
        end
        S_PUSH: begin
          if (free) begin
            out_r   <= res_r;
            state_r <= ret_r;
          end
        end
        S_ZERO: begin
          if (r_r == SIZE_W'(MAX_ROWS - 1)) state_r <= S_CNT_A;
          r_r <= r_r + 1'b1;
        end
        S_CNT_A: begin
          if (i_r == acnt_r) begin
            r_r     <= '0;
            run_r   <= '0;
            state_r <= S_PFX_A;
          end else begin
            state_r <= S_CNT_B;
          end
        end
        S_CNT_B: begin
          ent_r   <= amem_q;
          state_r <= S_CNT_C;
        end
        S_CNT_C: begin
          i_r     <= i_r + 1'b1;
          state_r <= S_CNT_A;
        end
        S_PFX_A: state_r <= S_PFX_B;
        S_PFX_B: begin
          run_r <= run_r + row_q;
          r_r   <= r_r + 1'b1;
          if (r_r == SIZE_W'(MAX_ROWS - 1)) begin
            i_r     <= '0;
            state_r <= S_PL_A;
          end else begin
            state_r <= S_PFX_A;
          end
        end
        S_PL_A: begin
          if (i_r == acnt_r) begin
            r_r        <= '0;
            prev_end_r <= '0;
            state_r    <= S_ROW_A;
          end else begin
            state_r <= S_PL_B;
          end
        end
        S_PL_B: begin
          ent_r   <= amem_q;
          state_r <= S_PL_C;
        end
        S_PL_C: begin
          i_r     <= i_r + 1'b1;
          state_r <= S_PL_A;
        end
        S_ROW_A: state_r <= S_ROW_B;
        S_ROW_B: begin
          ap_r       <= prev_end_r;
          ae_r       <= row_q;
          prev_end_r <= row_q;
          bp_r       <= bvalid_r[col_r[COL_AW-1:0]] ? bcol_q.first : '0;
          be_r       <= bvalid_r[col_r[COL_AW-1:0]] ? bcol_q.col_end : '0;
          sre_r      <= '0;
          sim_r      <= '0;
          state_r    <= S_MRG_A;
        end
        S_MRG_A: state_r <= (ap_r < ae_r && bp_r < be_r) ? S_MRG_B : S_FIN;
        S_MRG_B: begin
          state_r <= S_MRG_A;
          if (at_q.key == b_q.key) begin
            p0_r <= ar * br;
            p1_r <= ai * bi;
            p2_r <= ar * bi;
            p3_r <= ai * br;
            ap_r <= ap_r + 1'b1;
            bp_r <= bp_r + 1'b1;
          end else if (at_q.key < b_q.key) begin
            ap_r <= ap_r + 1'b1;
          end else begin
            bp_r <= bp_r + 1'b1;
          end
        end
        S_FIN: begin
          if (pass) begin
            pend_r   <= cur;
            pend_v_r <= 1'b1;
          end
          if (pass && pend_v_r) begin
            res_r   <= pend_r;
            ret_r   <= S_NEXT;
            state_r <= S_PUSH;
          end else begin
            state_r <= S_NEXT;
          end
        end
        S_NEXT: begin
          if (r_r + 1'b1 >= nrows) begin
            state_r <= S_END;
          end else begin
            r_r     <= r_r + 1'b1;
            state_r <= S_ROW_A;
          end
        end
        S_END: begin
          if (pend_v_r) begin
            res_r <= pend_last;
          end else begin
            res_r.out_row <= '0;
            res_r.out_col <= col_r;
            res_r.out_re  <= '0;
            res_r.out_im  <= '0;
            res_r.status  <= ST_EMPTY;
            res_r.last    <= 1'b1;
          end
          pend_v_r <= 1'b0;
          ret_r    <= S_IDLE;
          state_r  <= S_PUSH;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

[sv/sparse_complex_matrix_multiply.sv]
// top level of the sparse complex matrix multiply
//
// input channel: in_push / in_full, one beat per operation (clear, load A
// entry, load B entry, compute column). results: out_empty / out_pop, the
// oldest result sits on out_data while out_empty is low. cfg_valid /
// cfg_ready (always ready) writes the size and threshold registers.
// clears and loads are checked on entry and retire in the cycle they
// leave the 4-deep command queue, so a stream of loads runs at one beat
// per cycle while the back end is idle; an error gives one result, which
// passes through the queue and a reply register to the output register.
// a compute first rebuilds the row-major copy of A when A has changed:
// it clears the per-row counts, counts the A entries of each row, forms
// prefix sums of the counts and places each A entry. then each row reads
// its bounds, merges the row against column j and hands its result to the
// output register; the pace is bounded by the row-count memory and the
// single read port of each entry store.
// a single output register holds a result; while the receiver stalls the
// back end waits, the command queue fills and in_full rises.
// reset empties both stores and the queue and restores the sizes to 64
// and the threshold to 0.
`timescale 1ns / 1ps
module sparse_complex_matrix_multiply (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  scm_pkg::in_item_t  in_data,
  output logic               in_full,
  output logic               out_empty,
  input  logic               out_pop,
  output scm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  scm_pkg::cfg_idx_t  cfg_index,
  input  logic [scm_pkg::THR_W-1:0] cfg_data
);
  import scm_pkg::*;

  cfg_t cfg_r;
  logic cq_push, cq_full, cq_pop, cq_empty;
  cmd_t cq_wdata, cq_rdata;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rows_used      <= SIZE_RESET;
      cfg_r.inner_used     <= SIZE_RESET;
      cfg_r.cols_used      <= SIZE_RESET;
      cfg_r.zero_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_ROWS:  cfg_r.rows_used      <= cfg_data[SIZE_W-1:0];
        CFG_INNER: cfg_r.inner_used     <= cfg_data[SIZE_W-1:0];
        CFG_COLS:  cfg_r.cols_used      <= cfg_data[SIZE_W-1:0];
        CFG_THR:   cfg_r.zero_threshold <= cfg_data;
        default: ;
      endcase
    end
  end

  scm_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg_r),
    .in_push (in_push),
    .in_data (in_data),
    .in_full (in_full),
    .cq_push (cq_push),
    .cq_data (cq_wdata),
    .cq_full (cq_full)
  );

  scm_cmdq u_cmdq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (cq_push),
    .wdata (cq_wdata),
    .full  (cq_full),
    .pop   (cq_pop),
    .rdata (cq_rdata),
    .empty (cq_empty)
  );

  scm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .cq_empty  (cq_empty),
    .cq_data   (cq_rdata),
    .cq_pop    (cq_pop),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_data  (out_data)
  );

endmodule

[sv/scm_checker.sv]
// port-level checks for the sparse complex matrix multiply, bound to the top
`timescale 1ns / 1ps
module scm_port_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input scm_pkg::out_item_t out_data
);
  import scm_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_data))
    else $error("result beat changed while stalled");

  a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status != ST_OK |-> out_data.last)
    else $error("marker or error beat without last");

  a_single_zero: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status != ST_OK |-> out_data.out_re == '0 && out_data.out_im == '0)
    else $error("marker or error beat with nonzero value");

  a_empty_row: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && out_data.status == ST_EMPTY |-> out_data.out_row == '0)
    else $error("empty column marker with nonzero row");

endmodule

bind sparse_complex_matrix_multiply scm_port_checker u_scm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);

[tb/scm_checker.sv]
// result predictor and scoreboard for the sparse complex matrix multiply
`timescale 1ns / 1ps
module scm_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  input  scm_pkg::in_item_t  in_data,
  input  logic               in_full,
  input  logic               out_empty,
  input  logic               out_pop,
  input  scm_pkg::out_item_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  scm_pkg::cfg_idx_t  cfg_index,
  input  logic [scm_pkg::THR_W-1:0] cfg_data,
  output int                 fail_count,
  output int                 pending
);
  import scm_pkg::*;

  logic [SIZE_W-1:0] m_rows, m_inner, m_cols;
  logic [THR_W-1:0]  m_thr;
  logic [IDX_W-1:0]  a_row [NNZ_A];
  logic [IDX_W-1:0]  a_col [NNZ_A];
  logic [PVAL_W-1:0] a_val [NNZ_A];
  int                a_n;
  int                t_start [MAX_ROWS+1];
  logic [IDX_W-1:0]  t_col [NNZ_A];
  logic [PVAL_W-1:0] t_val [NNZ_A];
  bit                t_valid;
  int                b_start [MAX_COLS+1];
  logic [IDX_W-1:0]  b_row [NNZ_B];
  logic [PVAL_W-1:0] b_val [NNZ_B];
  int                b_n;
  out_item_t         expected_q [$];

  function automatic int eff(logic [SIZE_W-1:0] v, int mx);
    if (v == 0) return 1;
    if (int'(v) > mx) return mx;
    return int'(v);
  endfunction

  function automatic out_item_t mk(logic [IDX_W-1:0] r, logic [IDX_W-1:0] c,
                                   logic signed [SUM_W-1:0] re,
                                   logic signed [SUM_W-1:0] im, status_t s, logic l);
    out_item_t o;
    o.out_row = r; o.out_col = c; o.out_re = re; o.out_im = im;
    o.status = s; o.last = l;
    return o;
  endfunction

  task automatic enqueue(out_item_t o);
    expected_q.insert(expected_q.size(), o);
  endtask

  task automatic rebuild_rows();
    int pos [MAX_ROWS];
    for (int r = 0; r <= MAX_ROWS; r++) t_start[r] = 0;
    for (int i = 0; i < a_n; i++) t_start[a_row[i]+1]++;
    for (int r = 0; r < MAX_ROWS; r++) t_start[r+1] += t_start[r];
    for (int r = 0; r < MAX_ROWS; r++) pos[r] = t_start[r];
    for (int i = 0; i < a_n; i++) begin
      t_col[pos[a_row[i]]] = a_col[i];
      t_val[pos[a_row[i]]] = a_val[i];
      pos[a_row[i]]++;
    end
    t_valid = 1;
  endtask

  function automatic int b_tail_col();
    int lc;
    lc = 0;
    for (int c = 0; c < MAX_COLS; c++) if (b_start[c] < b_n) lc = c;
    return lc;
  endfunction

  task automatic predict(in_item_t it);
    int nr, ni, nc, n, ap, ae, bp, be, lc;
    longint sre, sim, ar, ai, br, bi, mre, mim;
    nr = eff(m_rows, MAX_ROWS);
    ni = eff(m_inner, MAX_INNER);
    nc = eff(m_cols, MAX_COLS);
    case (it.operation)
      OP_CLEAR: begin
        a_n = 0; b_n = 0; t_valid = 0;
        for (int k = 0; k <= MAX_ROWS; k++) t_start[k] = 0;
        for (int k = 0; k <= MAX_COLS; k++) b_start[k] = 0;
      end
      OP_LOAD_A: begin
        if (it.row_idx >= nr || it.col_idx >= ni ||
            (a_n > 0 && (it.col_idx < a_col[a_n-1] ||
             (it.col_idx == a_col[a_n-1] && it.row_idx <= a_row[a_n-1]))))
          enqueue(mk(it.row_idx, it.col_idx, 0, 0, ST_ERROR, 1));
        else if (a_n >= NNZ_A)
          enqueue(mk(it.row_idx, it.col_idx, 0, 0, ST_FULL, 1));
        else begin
          a_row[a_n] = it.row_idx; a_col[a_n] = it.col_idx;
          a_val[a_n] = {it.val_im, it.val_re};
          a_n++; t_valid = 0;
        end
      end
      OP_LOAD_B: begin
        lc = b_tail_col();
        if (it.row_idx >= ni || it.col_idx >= nc ||
            (b_n > 0 && (it.col_idx < lc ||
             (it.col_idx == lc && it.row_idx <= b_row[b_n-1]))))
          enqueue(mk(it.row_idx, it.col_idx, 0, 0, ST_ERROR, 1));
        else if (b_n >= NNZ_B)
          enqueue(mk(it.row_idx, it.col_idx, 0, 0, ST_FULL, 1));
        else begin
          b_row[b_n] = it.row_idx; b_val[b_n] = {it.val_im, it.val_re};
          b_n++;
          for (int c = it.col_idx + 1; c <= MAX_COLS; c++) b_start[c] = b_n;
        end
      end
      default: begin
        if (it.col_idx >= nc)
          enqueue(mk(0, it.col_idx, 0, 0, ST_ERROR, 1));
        else begin
          if (!t_valid) rebuild_rows();
          n = 0;
          for (int i = 0; i < nr; i++) begin
            ap = t_start[i]; ae = t_start[i+1];
            bp = b_start[it.col_idx]; be = b_start[it.col_idx+1];
            sre = 0; sim = 0;
            while (ap < ae && bp < be) begin
              if (t_col[ap] == b_row[bp]) begin
                ar = longint'($signed(t_val[ap][15:0]));
                ai = longint'($signed(t_val[ap][31:16]));
                br = longint'($signed(b_val[bp][15:0]));
                bi = longint'($signed(b_val[bp][31:16]));
                sre += ar * br - ai * bi;
                sim += ar * bi + ai * br;
                ap++; bp++;
              end else if (t_col[ap] < b_row[bp]) ap++;
              else bp++;
            end
            mre = sre < 0 ? -sre : sre;
            mim = sim < 0 ? -sim : sim;
            if (mre > longint'(m_thr) || mim > longint'(m_thr)) begin
              enqueue(mk(IDX_W'(i), it.col_idx, sre[SUM_W-1:0], sim[SUM_W-1:0],
                         ST_OK, 0));
              n++;
            end
          end
          if (n == 0) enqueue(mk(0, it.col_idx, 0, 0, ST_EMPTY, 1));
          else expected_q[$].last = 1;
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    out_item_t e;
    if (!rst_n) begin
      m_rows <= SIZE_RESET; m_inner <= SIZE_RESET; m_cols <= SIZE_RESET;
      m_thr <= '0;
      a_n = 0; b_n = 0; t_valid = 0;
      for (int k = 0; k <= MAX_ROWS; k++) t_start[k] = 0;
      for (int k = 0; k <= MAX_COLS; k++) b_start[k] = 0;
      fail_count <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ROWS:  m_rows  <= cfg_data[SIZE_W-1:0];
          CFG_INNER: m_inner <= cfg_data[SIZE_W-1:0];
          CFG_COLS:  m_cols  <= cfg_data[SIZE_W-1:0];
          default:   m_thr   <= cfg_data;
        endcase
      end
      if (out_pop && !out_empty) begin
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected result %p", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_q.pop_front();
          if (out_data !== e) begin
            $display("%0t: mismatch expected %p actual %p", $time, e, out_data);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_push && !in_full) predict(in_data);
    end
    pending <= expected_q.size();
  end

endmodule

[tb/sparse_complex_matrix_multiply_tb.sv]
// stimulus and verdict for the sparse complex matrix multiply
`timescale 1ns / 1ps
module sparse_complex_matrix_multiply_tb;
  import scm_pkg::*;

  logic clk = 0, rst_n = 0;
  logic in_push = 0, in_full, out_empty, out_pop = 0;
  in_item_t in_data = '0;
  out_item_t out_data;
  logic cfg_valid = 0, cfg_ready;
  cfg_idx_t cfg_index = CFG_ROWS;
  logic [THR_W-1:0] cfg_data = '0;
  int fail_count, pending;
  int cycles = 0;
  int idle_pct = 34;
  bit hold_off = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  sparse_complex_matrix_multiply u_dut (.*);

  scm_checker u_chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("sparse_complex_matrix_multiply_tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (hold_off) out_pop <= 0;
    else out_pop <= ($urandom_range(99) >= idle_pct);
  end

  task automatic send(op_t op, int r, int c, int re, int im);
    while ($urandom_range(99) < idle_pct) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_data <= '{op, r[5:0], c[5:0], re[15:0], im[15:0]};
    do @(posedge clk); while (in_full);
  endtask

  task automatic drain();
    in_push <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3000) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [THR_W-1:0] v);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic set_sizes(int r, int k, int c, logic [THR_W-1:0] t);
    write_reg(CFG_ROWS, THR_W'(r));
    write_reg(CFG_INNER, THR_W'(k));
    write_reg(CFG_COLS, THR_W'(c));
    write_reg(CFG_THR, t);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  // well-formed random matrices, then computes with some noise
  task automatic random_phase(int nr, int nk, int nc, int items);
    int col, row, sent;
    sent = 0;
    send(OP_CLEAR, 0, 0, 0, 0);
    col = 0; row = -1;
    while (sent < items / 3 && col < nk) begin
      row = row + 1 + $urandom_range(2);
      if (row >= nr) begin col++; row = -1; continue; end
      send(OP_LOAD_A, row, col, $urandom, $urandom);
      sent++;
    end
    col = 0; row = -1;
    while (sent < 2 * items / 3 && col < nc) begin
      row = row + 1 + $urandom_range(2);
      if (row >= nk) begin col++; row = -1; continue; end
      send(OP_LOAD_B, row, col, $urandom, $urandom);
      sent++;
    end
    while (sent < items) begin
      if ($urandom_range(9) == 0)
        send(op_t'($urandom_range(1, 2)), $urandom_range(63), $urandom_range(63),
             $urandom, $urandom);
      else send(OP_COMPUTE, 0, $urandom_range(nc), 0, 0);
      sent++;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: extremes, errors, empty column
    send(OP_COMPUTE, 0, 5, 0, 0);
    send(OP_LOAD_A, 0, 0, 16'h7fff, 16'h8000);
    send(OP_LOAD_A, 63, 0, 16'h8000, 16'h7fff);
    send(OP_LOAD_A, 63, 0, 1, 1);
    send(OP_LOAD_A, 5, 0, 1, 1);
    send(OP_LOAD_A, 2, 63, 16'hffff, 16'hffff);
    send(OP_LOAD_B, 0, 0, 16'h8000, 16'h8000);
    send(OP_LOAD_B, 63, 0, 16'h7fff, 16'h7fff);
    send(OP_LOAD_B, 63, 63, 16'hffff, 16'h0001);
    send(OP_LOAD_B, 10, 62, 1, 1);
    send(OP_COMPUTE, 0, 0, 0, 0);
    send(OP_COMPUTE, 0, 63, 0, 0);
    send(OP_COMPUTE, 0, 30, 0, 0);
    drain();
    set_sizes(4, 3, 2, 39'h7fffffffff);
    send(OP_LOAD_A, 4, 0, 1, 1);
    send(OP_LOAD_B, 0, 2, 1, 1);
    send(OP_COMPUTE, 0, 2, 0, 0);
    send(OP_COMPUTE, 0, 0, 0, 0);
    send(OP_CLEAR, 0, 0, 0, 0);
    send(OP_LOAD_A, 3, 2, 16'h7fff, 0);
    send(OP_LOAD_B, 2, 1, 16'h7fff, 0);
    send(OP_COMPUTE, 0, 1, 0, 0);
    drain();
    set_sizes(0, 0, 0, 0);
    send(OP_LOAD_A, 0, 0, 3, 4);
    send(OP_LOAD_B, 0, 0, 5, 6);
    send(OP_COMPUTE, 0, 0, 0, 0);
    send(OP_COMPUTE, 0, 1, 0, 0);
    drain();
    // random phases, the middle one without idling
    set_sizes(8, 8, 8, 0);
    random_phase(8, 8, 8, 30);
    drain();
    idle_pct = 0;
    set_sizes(16, 6, 4, 39'd20000);
    random_phase(16, 6, 4, 30);
    drain();
    idle_pct = 34;
    // receiver stalls while computes pile up
    hold_off = 1;
    fork
      begin repeat (600) @(posedge clk); hold_off = 0; end
      repeat (12) send(OP_COMPUTE, 0, $urandom_range(3), 0, 0);
    join
    drain();
    set_sizes(64, 64, 64, 39'd100);
    random_phase(64, 64, 64, 25);
    drain();
    if (fail_count == 0) $display("sparse_complex_matrix_multiply_tb: PASS");
    else $display("sparse_complex_matrix_multiply_tb: FAIL");
    $finish;
  end

endmodule
